// File: rtl/core/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the B-spline curve point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

	// item modes
	localparam logic [1:0] MODE_KNOT  = 2'd0;
	localparam logic [1:0] MODE_POINT = 2'd1;
	localparam logic [1:0] MODE_EVAL  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_EVAL   = 2'd0;
	localparam logic [1:0] ST_STORED = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// configuration register indexes
	localparam logic CFG_DEGREE = 1'b0;
	localparam logic CFG_POINTS = 1'b1;

	// t = 1.0 in Q1.16, basis 1.0 in Q1.30
	localparam logic [16:0]        T_ONE     = 17'd65536;
	localparam logic signed [31:0] BASIS_ONE = 32'sh4000_0000;

	localparam logic [1:0] DEGREE_RESET = 2'd3;
	localparam logic [4:0] POINTS_RESET = 5'd4;

	// input item
	typedef struct packed {
		logic [1:0]         mode;
		logic [4:0]         index;
		logic signed [19:0] knot_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [16:0]        param_t;
	} in_item_t;

	// result item
	typedef struct packed {
		logic signed [31:0] curve_x;
		logic signed [31:0] curve_y;
		logic signed [31:0] curve_z;
		logic [4:0]         span;
		logic [1:0]         status;
	} out_item_t;

	// classified command from front to back
	typedef enum logic [1:0] {
		CMD_KNOT,
		CMD_POINT,
		CMD_EVAL,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [4:0]         index;
		logic signed [19:0] knot_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [16:0]        param_t;
	} cmd_t;

	// saturate a 33-bit sum to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31])
			r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/core/bcpe_fifo.sv
// ----------------------------------------------------------------------------
// bcpe_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module bcpe_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     wr_data,
	input  logic pop,
	output logic empty,
	output T     rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/bcpe_front.sv
// ----------------------------------------------------------------------------
// bcpe_front
// Takes input items, sorts them into knot store, point store, evaluate or
// reject, and queues the commands for the back end.
// ----------------------------------------------------------------------------
module bcpe_front import bcpe_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int MAX_KNOTS  = 20
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     cmd_pop,
	output logic     cmd_empty,
	output cmd_t     cmd
);

	cmd_t cls;

	// classify by mode, index range and t range
	always_comb begin
		cls.index      = item.index;
		cls.knot_value = item.knot_value;
		cls.point_x    = item.point_x;
		cls.point_y    = item.point_y;
		cls.point_z    = item.point_z;
		cls.param_t    = item.param_t;
		unique case (item.mode)
			MODE_KNOT:  cls.kind = (int'(item.index) < MAX_KNOTS) ? CMD_KNOT : CMD_REJECT;
			MODE_POINT: cls.kind = (int'(item.index) < MAX_POINTS) ? CMD_POINT : CMD_REJECT;
			MODE_EVAL:  cls.kind = (item.param_t > T_ONE) ? CMD_REJECT : CMD_EVAL;
			default:    cls.kind = CMD_REJECT;
		endcase
	end

	// command queue to the back end
	bcpe_fifo #(
		.T     (cmd_t),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_data (cls),
		.pop     (cmd_pop),
		.empty   (cmd_empty),
		.rd_data (cmd)
	);

endmodule

// File: rtl/core/bcpe_back.sv
// ----------------------------------------------------------------------------
// bcpe_back
// Executes commands: store writes, span search, Cox-de Boor basis triangle
// on a shared multiply and bit-serial divide unit, and the weighted sum.
// ----------------------------------------------------------------------------
module bcpe_back import bcpe_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int MAX_DEGREE = 3,
	parameter int MAX_KNOTS  = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [4:0] cfg_data,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	input  cmd_t      cmd,
	input  logic      res_full,
	output logic      res_push,
	output out_item_t res
);

	localparam int KW  = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int BW  = $clog2(MAX_DEGREE + 1);
	localparam int AW0 = (KW > PW) ? KW : PW;
	localparam int AW  = (AW0 > 6) ? AW0 : 6;
	localparam int QW  = 53;
	localparam int CW  = $clog2(QW);

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_HI_W, S_HI_U, S_LO_W, S_LO_U, S_SRCH_W, S_SRCH_U, S_BASIS,
		S_TA, S_TA_W, S_TA_U, S_TB_W, S_TB_U, S_MUL, S_DIV, S_TEND, S_TNEXT,
		S_WA, S_WW, S_WU, S_WACC, S_WFIN, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0] degree_q;
	logic [4:0] points_q;

	// stores
	logic signed [19:0] knot_mem [MAX_KNOTS];
	logic signed [31:0] ptx_mem [MAX_POINTS];
	logic signed [31:0] pty_mem [MAX_POINTS];
	logic signed [31:0] ptz_mem [MAX_POINTS];
	logic signed [19:0] knot_rd_q;
	logic signed [31:0] ptx_rd_q;
	logic signed [31:0] pty_rd_q;
	logic signed [31:0] ptz_rd_q;
	logic [AW-1:0]      kaddr_q;
	logic [AW-1:0]      paddr_q;

	// sequencer state
	logic [16:0]         t_q;
	logic signed [20:0]  hi_q;
	logic [AW-1:0]       span_q;
	logic [AW-1:0]       iter_q;
	logic [BW-1:0]       j_q;
	logic [BW-1:0]       r_q;
	logic                term2_q;
	logic [1:0]          ax_q;
	logic signed [31:0]  basis_q [MAX_DEGREE+1];
	logic signed [19:0]  a_q;
	logic [20:0]         numabs_q;
	logic [20:0]         denabs_q;
	logic                den_zero_q;
	logic                neg_q;
	logic [QW-1:0]       dq_q;
	logic [20:0]         rem_q;
	logic [CW-1:0]       cnt_q;
	logic signed [32:0]  acc_q;
	logic signed [63:0]  wprod_q;
	logic signed [55:0]  wacc_q;
	out_item_t           res_q;

	// combinational helpers
	logic               take;
	logic               knot_we;
	logic               pt_we;
	logic               cfg_bad;
	logic signed [20:0] t_s;
	logic signed [20:0] k_s;
	logic signed [20:0] a_s;
	logic signed [20:0] num;
	logic signed [20:0] den;
	logic [BW-1:0]      bidx;
	logic signed [31:0] nprev;
	logic [31:0]        nabs;
	logic [21:0]        trial;
	logic [31:0]        q32;
	logic               q_ovf;
	logic signed [31:0] term;
	logic signed [31:0] psel;
	logic signed [55:0] wsh;
	logic signed [31:0] wsat;
	logic [AW-1:0]      k_base;

	assign take     = (state_q == S_IDLE) && !cmd_empty;
	assign cmd_pop  = take;
	assign knot_we  = take && (cmd.kind == CMD_KNOT);
	assign pt_we    = take && (cmd.kind == CMD_POINT);
	assign res_push = (state_q == S_DONE) && !res_full;
	assign res      = res_q;

	assign cfg_bad = (int'(degree_q) > MAX_DEGREE) || (int'(points_q) > MAX_POINTS) ||
		(points_q < 5'(degree_q) + 5'd1) ||
		(int'(points_q) + int'(degree_q) + 1 > MAX_KNOTS);

	// term operands
	assign t_s    = $signed({4'b0, t_q});
	assign k_s    = {knot_rd_q[19], knot_rd_q};
	assign a_s    = {a_q[19], a_q};
	assign num    = term2_q ? (k_s - t_s) : (t_s - a_s);
	assign den    = k_s - a_s;
	assign bidx   = term2_q ? r_q : r_q - BW'(1);
	assign nprev  = basis_q[bidx];
	assign nabs   = nprev[31] ? 32'(-nprev) : 32'(nprev);
	assign trial  = {rem_q, dq_q[QW-1]};
	assign k_base = span_q - AW'(j_q) + AW'(r_q) + AW'(term2_q);

	// quotient sign and saturation
	always_comb begin
		q32 = dq_q[31:0];
		if (neg_q)
			q_ovf = (dq_q[QW-1:32] != '0) || (dq_q[31] && (dq_q[30:0] != '0));
		else
			q_ovf = (dq_q[QW-1:31] != '0);
		if (q_ovf)
			term = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			term = neg_q ? $signed(-q32) : $signed(q32);
	end

	// weighted sum: axis select, rounding and saturation
	always_comb begin
		case (ax_q)
			AX_X:    psel = ptx_rd_q;
			AX_Y:    psel = pty_rd_q;
			default: psel = ptz_rd_q;
		endcase
		wsh = (wacc_q + 56'sd32768) >>> 16;
		if (wsh > 56'sd2147483647)
			wsat = 32'sh7fff_ffff;
		else if (wsh < -56'sd2147483648)
			wsat = 32'sh8000_0000;
		else
			wsat = wsh[31:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
			points_q <= POINTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEGREE: degree_q <= cfg_data[1:0];
				CFG_POINTS: points_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// knot store, registered read
	always_ff @(posedge clk) begin
		if (knot_we)
			knot_mem[KW'(cmd.index)] <= cmd.knot_value;
		knot_rd_q <= knot_mem[kaddr_q[KW-1:0]];
	end

	// control point stores, registered read
	always_ff @(posedge clk) begin
		if (pt_we) begin
			ptx_mem[PW'(cmd.index)] <= cmd.point_x;
			pty_mem[PW'(cmd.index)] <= cmd.point_y;
			ptz_mem[PW'(cmd.index)] <= cmd.point_z;
		end
		ptx_rd_q <= ptx_mem[paddr_q[PW-1:0]];
		pty_rd_q <= pty_mem[paddr_q[PW-1:0]];
		ptz_rd_q <= ptz_mem[paddr_q[PW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						res_q.curve_x <= '0;
						res_q.curve_y <= '0;
						res_q.curve_z <= '0;
						res_q.span    <= '0;
						t_q           <= cmd.param_t;
						kaddr_q       <= AW'(points_q);
						unique case (cmd.kind) inside
							CMD_KNOT, CMD_POINT: begin
								res_q.status <= ST_STORED;
								state_q      <= S_DONE;
							end
							CMD_EVAL: begin
								res_q.status <= ST_REJECT;
								state_q      <= cfg_bad ? S_DONE : S_HI_W;
							end
							default: begin
								res_q.status <= ST_REJECT;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				// range check against U[n] and U[p]
				S_HI_W: state_q <= S_HI_U;
				S_HI_U: begin
					hi_q    <= k_s;
					kaddr_q <= AW'(degree_q);
					state_q <= (t_s > k_s) ? S_DONE : S_LO_W;
				end
				S_LO_W: state_q <= S_LO_U;
				S_LO_U: begin
					iter_q  <= AW'(degree_q) + AW'(1);
					kaddr_q <= AW'(degree_q) + AW'(1);
					if (t_s < k_s) begin
						state_q <= S_DONE;
					end else if (t_s == hi_q) begin
						span_q  <= AW'(points_q) - AW'(1);
						state_q <= S_BASIS;
					end else begin
						span_q  <= AW'(degree_q);
						state_q <= (AW'(degree_q) + AW'(1) < AW'(points_q)) ? S_SRCH_W : S_BASIS;
					end
				end
				// span search, one knot per visit
				S_SRCH_W: state_q <= S_SRCH_U;
				S_SRCH_U: begin
					if (k_s <= t_s) begin
						span_q  <= iter_q;
						iter_q  <= iter_q + AW'(1);
						kaddr_q <= iter_q + AW'(1);
						state_q <= (iter_q + AW'(1) < AW'(points_q)) ? S_SRCH_W : S_BASIS;
					end else begin
						state_q <= S_BASIS;
					end
				end
				// clear the triangle, seed N[0] = 1
				S_BASIS: begin
					for (int e = 1; e <= MAX_DEGREE; e++)
						basis_q[e] <= '0;
					basis_q[0] <= BASIS_ONE;
					acc_q      <= '0;
					wacc_q     <= '0;
					ax_q       <= AX_X;
					j_q        <= BW'(1);
					r_q        <= (degree_q == '0) ? '0 : BW'(1);
					term2_q    <= 1'b0;
					state_q    <= (degree_q == '0) ? S_WA : S_TA;
				end
				// fetch the two knots of one term
				S_TA: begin
					kaddr_q <= k_base;
					state_q <= S_TA_W;
				end
				S_TA_W: state_q <= S_TA_U;
				S_TA_U: begin
					a_q     <= knot_rd_q;
					kaddr_q <= kaddr_q + AW'(j_q);
					state_q <= S_TB_W;
				end
				S_TB_W: state_q <= S_TB_U;
				S_TB_U: begin
					numabs_q   <= num[20] ? 21'(-num) : 21'(num);
					denabs_q   <= den[20] ? 21'(-den) : 21'(den);
					den_zero_q <= (den == '0);
					neg_q      <= num[20] ^ den[20];
					state_q    <= S_MUL;
				end
				// magnitude product num * N
				S_MUL: begin
					dq_q    <= numabs_q * nabs;
					neg_q   <= neg_q ^ nprev[31];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= den_zero_q ? S_TNEXT : S_DIV;
				end
				// restoring divide, one quotient bit per cycle
				S_DIV: begin
					if (trial >= {1'b0, denabs_q}) begin
						rem_q <= 21'(trial - {1'b0, denabs_q});
						dq_q  <= {dq_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= trial[20:0];
						dq_q  <= {dq_q[QW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QW - 1))
						state_q <= S_TEND;
				end
				S_TEND: begin
					acc_q   <= acc_q + {term[31], term};
					state_q <= S_TNEXT;
				end
				// step through the triangle, top row entry first
				S_TNEXT: begin
					if (!term2_q && (r_q < j_q)) begin
						term2_q <= 1'b1;
						state_q <= S_TA;
					end else begin
						basis_q[r_q] <= sat33(acc_q);
						acc_q        <= '0;
						if (r_q == '0) begin
							if (AW'(j_q) == AW'(degree_q)) begin
								state_q <= S_WA;
							end else begin
								j_q     <= j_q + BW'(1);
								r_q     <= j_q + BW'(1);
								term2_q <= 1'b0;
								state_q <= S_TA;
							end
						end else begin
							r_q     <= r_q - BW'(1);
							term2_q <= (r_q == BW'(1));
							state_q <= S_TA;
						end
					end
				end
				// weighted sum per axis
				S_WA: begin
					paddr_q <= span_q - AW'(degree_q) + AW'(r_q);
					state_q <= S_WW;
				end
				S_WW: state_q <= S_WU;
				S_WU: begin
					wprod_q <= psel * basis_q[r_q];
					state_q <= S_WACC;
				end
				S_WACC: begin
					wacc_q <= wacc_q + 56'(wprod_q >>> 14);
					if (AW'(r_q) == AW'(degree_q)) begin
						state_q <= S_WFIN;
					end else begin
						r_q     <= r_q + BW'(1);
						state_q <= S_WA;
					end
				end
				S_WFIN: begin
					case (ax_q)
						AX_X:    res_q.curve_x <= wsat;
						AX_Y:    res_q.curve_y <= wsat;
						default: res_q.curve_z <= wsat;
					endcase
					wacc_q <= '0;
					r_q    <= '0;
					if (ax_q == AX_Z) begin
						res_q.span   <= span_q[4:0];
						res_q.status <= ST_EVAL;
						state_q      <= S_DONE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_WA;
					end
				end
				S_DONE: begin
					if (!res_full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/bspline_curve_point_eval.sv
// ----------------------------------------------------------------------------
// bspline_curve_point_eval
// B-spline curve point evaluator: knot and control point stores, span
// search, Cox-de Boor basis and saturated weighted sum in Q15.16.
// ----------------------------------------------------------------------------
// Every item gives one result. Store and rejected items go from idle straight
// to the done state of the back end. An evaluation runs the range check, the
// span search one knot per visit, the basis terms (p*(p+1) of them, each
// through the 53-step bit-serial divider unless its interval has zero width)
// and the weighted sum over the p+1 points of the span for each axis. Two-entry
// queues sit between the input, the sequencer and the result side, so items
// and results move while an evaluation runs. Configuration is taken on any
// cycle with cfg_we high; write it only while no item is in flight.
module bspline_curve_point_eval import bcpe_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int MAX_DEGREE = 3,
	parameter int MAX_KNOTS  = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   item,
	output logic       empty,
	input  logic       pop,
	output out_item_t  result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data
);

	logic      cmd_empty;
	logic      cmd_pop;
	cmd_t      cmd;
	logic      res_full;
	logic      res_push;
	out_item_t res;

	// classification and command queue
	bcpe_front #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_KNOTS  (MAX_KNOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd       (cmd)
	);

	// execution
	bcpe_back #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_DEGREE (MAX_DEGREE),
		.MAX_KNOTS  (MAX_KNOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	bcpe_fifo #(
		.T     (out_item_t),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.wr_data (res),
		.pop     (pop),
		.empty   (empty),
		.rd_data (result)
	);

endmodule

// File: tb/sv/bspline_curve_point_eval_tb.sv
// ----------------------------------------------------------------------------
// bspline_curve_point_eval_tb
// Self-checking bench for the B-spline curve point evaluator: loads knot and
// control point stores, evaluates curves at several degree and point-count
// settings, and compares every result with a bit-true predictor.
// ----------------------------------------------------------------------------
module bspline_curve_point_eval_tb;
	import bcpe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 16;
	localparam int NKNOTS = 20;
	localparam int NDEG = 3;
	localparam longint CYCLE_LIMIT = 64'd8_000_000;

	// curve state and predictor
	class curve_scoreboard;
		longint knots[NKNOTS];
		longint px[NPTS], py[NPTS], pz[NPTS];
		int deg_r = 3, npts_r = 4;
		out_item_t pending[$];
		int errors, evals, stores, rejects;

		function void set_reg(logic idx, logic [4:0] v);
			if (idx == CFG_DEGREE) deg_r = int'(v[1:0]);
			else npts_r = int'(v);
		endfunction

		function longint sat32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint kat(int i);
			return (i < NKNOTS) ? knots[i] : 0;
		endfunction

		function longint fshift(longint x, int s);
			if (x >= 0) return x >>> s;
			return -((-x - 1) >>> s) - 1;
		endfunction

		function longint bterm(longint num, longint nb, longint den);
			if (den == 0) return 0;
			return sat32((num * nb) / den);
		endfunction

		function void note_item(in_item_t it);
			out_item_t o;
			longint t, acc, ax, ay, az;
			longint basis[NDEG+1];
			int p, n, sp, k;
			o = '0;
			o.status = ST_REJECT;
			p = deg_r;
			n = npts_r;
			t = it.param_t;
			if (it.mode == MODE_KNOT) begin
				if (it.index < NKNOTS) begin
					knots[it.index] = it.knot_value;
					o.status = ST_STORED;
				end
			end else if (it.mode == MODE_POINT) begin
				if (it.index < NPTS) begin
					px[it.index] = it.point_x;
					py[it.index] = it.point_y;
					pz[it.index] = it.point_z;
					o.status = ST_STORED;
				end
			end else if (it.mode == MODE_EVAL && t <= 65536 && p <= NDEG && n <= NPTS
					&& n >= p + 1 && n + p + 1 <= NKNOTS && t >= kat(p) && t <= kat(n)) begin
				if (t == kat(n)) sp = n - 1;
				else begin
					sp = p;
					for (int i = p + 1; i < n; i++) begin
						if (kat(i) <= t) sp = i;
						else break;
					end
				end
				foreach (basis[i]) basis[i] = 0;
				basis[0] = 64'sd1 << 30;
				for (int j = 1; j <= p; j++) begin
					for (int r = j; r >= 0; r--) begin
						k = sp - j + r;
						acc = 0;
						if (r >= 1)
							acc += bterm(t - kat(k), basis[r-1], kat(k+j) - kat(k));
						if (r < j)
							acc += bterm(kat(k+j+1) - t, basis[r], kat(k+j+1) - kat(k+1));
						basis[r] = sat32(acc);
					end
				end
				ax = 0; ay = 0; az = 0;
				for (int r = 0; r <= p; r++) begin
					k = sp - p + r;
					ax += fshift(((k < NPTS) ? px[k] : 0) * basis[r], 14);
					ay += fshift(((k < NPTS) ? py[k] : 0) * basis[r], 14);
					az += fshift(((k < NPTS) ? pz[k] : 0) * basis[r], 14);
				end
				o.curve_x = 32'(sat32(fshift(ax + 32768, 16)));
				o.curve_y = 32'(sat32(fshift(ay + 32768, 16)));
				o.curve_z = 32'(sat32(fshift(az + 32768, 16)));
				o.span = 5'(sp);
				o.status = ST_EVAL;
			end
			case (o.status)
				ST_EVAL: evals++;
				ST_STORED: stores++;
				default: rejects++;
			endcase
			pending.push_back(o);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.curve_x !== e.curve_x) begin
				$display("%0t: curve_x exp %h got %h", $realtime, e.curve_x, got.curve_x);
				errors++;
			end
			if (got.curve_y !== e.curve_y) begin
				$display("%0t: curve_y exp %h got %h", $realtime, e.curve_y, got.curve_y);
				errors++;
			end
			if (got.curve_z !== e.curve_z) begin
				$display("%0t: curve_z exp %h got %h", $realtime, e.curve_z, got.curve_z);
				errors++;
			end
			if (got.span !== e.span) begin
				$display("%0t: span exp %0d got %0d", $realtime, e.span, got.span);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [4:0] cfg_data = '0;

	curve_scoreboard sb = new();
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit fast_phase = 1'b0;
	int items_sent = 0;
	int cur_deg = 3, cur_n = 4;
	bit knots_written[NKNOTS];

	bspline_curve_point_eval DUT (.*);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random pop gaps, one long hold-off on request
	initial begin : result_side
		int gap;
		@(negedge clk);
		forever begin
			gap = fast_phase ? 0 : $urandom_range(0, 12);
			if (gap != 0 || hold_off) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
				while (hold_off) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			sb.check_result(result);
			@(negedge clk);
		end
	end

	// one transfer into the block; push stays high for a following item
	task automatic send(in_item_t it);
		int gap;
		gap = fast_phase ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (1000) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		if (idx == CFG_DEGREE) cur_deg = int'(v[1:0]);
		else cur_n = int'(v);
	endtask

	function automatic in_item_t knot_item(int idx, logic signed [19:0] v);
		in_item_t it;
		it = '0;
		it.mode = MODE_KNOT;
		it.index = 5'(idx);
		it.knot_value = v;
		return it;
	endfunction

	function automatic in_item_t point_item(int idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		in_item_t it;
		it = '0;
		it.mode = MODE_POINT;
		it.index = 5'(idx);
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		return it;
	endfunction

	function automatic in_item_t eval_item(int t);
		in_item_t it;
		it = '0;
		it.mode = MODE_EVAL;
		it.param_t = 17'(t);
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 65536 * 8) - 65536 * 4;
			default: return $urandom;
		endcase
	endfunction

	// load a sorted knot vector inside [0, 1] plus all control points
	task automatic load_curve(bit clamped);
		int nk, v;
		nk = cur_n + cur_deg + 1;
		v = 0;
		for (int i = 0; i < nk; i++) begin
			if (clamped && i <= cur_deg) v = 0;
			else if (clamped && i >= cur_n) v = 65536;
			else if ($urandom_range(0, 3) != 0)
				v = v + $urandom_range(0, (65536 - v) / 2);
			if (v > 65536) v = 65536;
			send(knot_item(i, 20'(v)));
			knots_written[i] = 1'b1;
		end
		for (int i = 0; i < cur_n; i++)
			send(point_item(i, rand_coord(), rand_coord(), rand_coord()));
	endtask

	// eval or noise, never touching unwritten knots
	task automatic random_item();
		in_item_t it;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 13) begin
			it = eval_item($urandom_range(0, 3) == 0 ?
				int'(sb.kat(cur_n)) : $urandom_range(sb.kat(cur_deg), sb.kat(cur_n)));
		end else if (sel < 15) begin
			it = point_item($urandom_range(0, cur_n - 1), rand_coord(), rand_coord(),
				rand_coord());
		end else if (sel < 17) begin
			it = '0;
			it.mode = $urandom_range(0, 1) ? MODE_KNOT : MODE_POINT;
			it.index = 5'($urandom_range(NKNOTS, 31));
			if (it.mode == MODE_POINT) it.index = 5'($urandom_range(NPTS, 31));
			it.knot_value = 20'($urandom);
			it.point_x = $urandom;
			it.param_t = 17'($urandom);
		end else if (sel < 18) begin
			it = $urandom;
			it.mode = 2'd3;
			it.point_x = $urandom;
			it.point_y = $urandom;
		end else begin
			it = eval_item($urandom_range(65537, 131071));
		end
		send(it);
	endtask

	initial begin : stimulus
		int settings[6][2] = '{'{3, 4}, '{1, 2}, '{3, 16}, '{2, 9}, '{1, 16}, '{2, 3}};
		in_item_t it;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset config, extremes, zero-width intervals, top knot
		write_reg(CFG_DEGREE, 5'd3);
		write_reg(CFG_POINTS, 5'd4);
		send(knot_item(0, 0)); send(knot_item(1, 0));
		send(knot_item(2, 0)); send(knot_item(3, 0));
		send(knot_item(4, 20'sh10000)); send(knot_item(5, 20'sh10000));
		send(knot_item(6, 20'sh10000)); send(knot_item(7, 20'sh10000));
		send(knot_item(19, 20'sh7ffff)); send(knot_item(18, 20'sh80000));
		knots_written[18] = 1; knots_written[19] = 1;
		for (int i = 0; i < 8; i++) knots_written[i] = 1;
		send(point_item(0, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
		send(point_item(1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
		send(point_item(2, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000));
		send(point_item(15, 32'h7fff_ffff, 32'h8000_0000, 32'h5555_aaaa));
		send(point_item(3, 32'h7fff_ffff, 32'h8000_0000, 32'haaaa_5555));
		send(eval_item(0));
		send(eval_item(32768));
		send(eval_item(65536));
		send(eval_item(65537));
		send(eval_item(17'h1ffff));
		send(eval_item(40000));
		send(point_item(16, '1, '1, '1));
		send(knot_item(20, 20'h0));
		it = '1;
		send(it);
		drain();
		// unusable configuration: too few points for the degree
		write_reg(CFG_POINTS, 5'd3);
		send(eval_item(0));
		drain();
		write_reg(CFG_DEGREE, 5'd0);
		write_reg(CFG_POINTS, 5'd31);
		send(eval_item(0));
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_DEGREE, 5'(settings[ph % 6][0]));
			write_reg(CFG_POINTS, 5'(settings[ph % 6][1]));
			load_curve(ph % 3 != 2);
			fast_phase = (ph == 4);
			if (ph == 3) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (3000) @(negedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			repeat (75) random_item();
			fast_phase = 1'b0;
			drain();
		end

		$display("Covered %0d items: %0d evaluations, %0d stores, %0d rejects,",
			items_sent, sb.evals, sb.stores, sb.rejects);
		$display("degrees 1 to 3 and point counts 2 to 16, with input back-pressure.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
